[src/apw_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apw_pkg: shared types and constants of the average pool window unit
// Item layouts, configuration set, divider handshake and sequencer states.
// ---------------------------------------------------------------------------
package apw_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CHAN_W    = 4;
  localparam int COUNT_W   = 7;
  localparam int WIN_LIMIT = 8;
  // 64 samples of 16 bits need 22 bits signed
  localparam int SUM_W     = SAMPLE_W + 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 7;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ROWS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COLS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_ROWS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_COLS   = 3'd7;

  typedef struct packed {
    logic                       operation;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [COUNT_W-1:0]         window_count;
  } out_item_t;

  typedef struct packed {
    logic [6:0] image_height;
    logic [6:0] image_width;
    logic [3:0] window_height;
    logic [3:0] window_width;
    logic [3:0] step_rows;
    logic [3:0] step_cols;
    logic [2:0] margin_rows;
    logic [2:0] margin_cols;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT
  } seq_state_t;

endpackage

[src/apw_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apw_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ---------------------------------------------------------------------------
module apw_div (
  input  logic              clk,
  input  logic              rst_n,
  input  apw_pkg::div_req_t req,
  output apw_pkg::div_rsp_t rsp
);

  localparam int SUM_W   = apw_pkg::SUM_W;
  localparam int COUNT_W = apw_pkg::COUNT_W;
  localparam int STEP_W  = $clog2(SUM_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic [COUNT_W-1:0]  den_r, den_nxt;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [COUNT_W:0]    rem_sh;
  logic                ge;

  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(SUM_W);
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? COUNT_W'(rem_sh - {1'b0, den_r}) : COUNT_W'(rem_sh);
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[src/apw_seq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apw_seq: image store and window sequencer
// Holds the sample memory, clips the window, walks it one read per cycle,
// accumulates and hands the sum to the serial divider.
// ---------------------------------------------------------------------------
module apw_seq #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int MAX_CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  apw_pkg::cfg_t      cfg,
  input  logic               start,
  input  apw_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output apw_pkg::out_item_t out_item,
  output apw_pkg::div_req_t  div_req,
  input  apw_pkg::div_rsp_t  div_rsp
);

  localparam int SAMPLE_W = apw_pkg::SAMPLE_W;
  localparam int SUM_W    = apw_pkg::SUM_W;
  localparam int COUNT_W  = apw_pkg::COUNT_W;
  localparam int CHAN_W   = apw_pkg::CHAN_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_q_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;

  apw_pkg::seq_state_t state_r, state_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                out_valid_r, out_valid_nxt;
  apw_pkg::out_item_t  out_item_r, out_item_nxt;

  logic [5:0]          req_row_r, req_row_nxt;
  logic [5:0]          req_col_r, req_col_nxt;
  logic [CHAN_W-1:0]   ch_r, ch_nxt;
  logic [6:0]          h_end_r, h_end_nxt;
  logic [6:0]          w_start_r, w_start_nxt, w_end_r, w_end_nxt;
  logic [6:0]          h_r, h_nxt, w_r, w_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  logic                accept;
  logic [9:0]          row_prod, col_prod;
  logic signed [11:0]  h0s, w0s, h1_raw, w1_raw, h1s, w1s, h0c, w0c;
  logic [3:0]          wh_sat, ww_sat;
  logic [6:0]          h_lim, w_lim;
  logic                chan_ok, empty;
  logic [SUM_W-1:0]    sum_mag;
  logic [SUM_W-1:0]    q_signed;

  assign accept = start && !busy;

  // stores land at the accept edge, out-of-range coordinates are dropped
  assign mem_we = accept && (in_item.operation == apw_pkg::OP_STORE)
                  && (32'(in_item.row) < MAX_ROWS) && (32'(in_item.col) < MAX_COLS)
                  && (32'(in_item.channel) < MAX_CHANNELS);
  assign mem_waddr = ADDR_W'((32'(in_item.row) * MAX_COLS + 32'(in_item.col))
                             * MAX_CHANNELS + 32'(in_item.channel));
  assign mem_raddr = ADDR_W'((32'(h_r) * MAX_COLS + 32'(w_r)) * MAX_CHANNELS + 32'(ch_r));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_item.sample;
    end
    rd_q_r <= mem[mem_raddr];
  end

  // window bounds, signed so that the margin may push the start negative
  always_comb begin
    row_prod = 10'(req_row_r) * 10'(cfg.step_rows);
    col_prod = 10'(req_col_r) * 10'(cfg.step_cols);
    h0s      = $signed({2'b00, row_prod}) - $signed({9'b0, cfg.margin_rows});
    w0s      = $signed({2'b00, col_prod}) - $signed({9'b0, cfg.margin_cols});
    wh_sat   = (cfg.window_height > 4'(apw_pkg::WIN_LIMIT)) ? 4'(apw_pkg::WIN_LIMIT)
                                                            : cfg.window_height;
    ww_sat   = (cfg.window_width > 4'(apw_pkg::WIN_LIMIT)) ? 4'(apw_pkg::WIN_LIMIT)
                                                           : cfg.window_width;
    h_lim    = (32'(cfg.image_height) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg.image_height;
    w_lim    = (32'(cfg.image_width) > MAX_COLS) ? 7'(MAX_COLS) : cfg.image_width;
    h1_raw   = h0s + $signed({8'b0, wh_sat});
    w1_raw   = w0s + $signed({8'b0, ww_sat});
    h1s      = (h1_raw > $signed({5'b0, h_lim})) ? $signed({5'b0, h_lim}) : h1_raw;
    w1s      = (w1_raw > $signed({5'b0, w_lim})) ? $signed({5'b0, w_lim}) : w1_raw;
    h0c      = h0s[11] ? 12'sd0 : h0s;
    w0c      = w0s[11] ? 12'sd0 : w0s;
    chan_ok  = (32'(ch_r) < MAX_CHANNELS);
    empty    = !chan_ok || (h0c >= h1s) || (w0c >= w1s);
  end

  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign q_signed = sum_r[SUM_W-1] ? SUM_W'(-div_rsp.quotient) : div_rsp.quotient;

  always_comb begin
    state_nxt     = state_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    req_row_nxt   = req_row_r;
    req_col_nxt   = req_col_r;
    ch_nxt        = ch_r;
    h_end_nxt     = h_end_r;
    w_start_nxt   = w_start_r;
    w_end_nxt     = w_end_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    div_req.start    = 1'b0;
    div_req.dividend = sum_mag;
    div_req.divisor  = count_r;

    // read data is registered, so it arrives in the cycle after its address
    if (rd_vld_r) begin
      sum_nxt   = sum_r + $signed({{(SUM_W-SAMPLE_W){rd_q_r[SAMPLE_W-1]}}, rd_q_r});
      count_nxt = count_r + COUNT_W'(1);
    end

    unique case (state_r)
      apw_pkg::ST_IDLE: begin
        if (accept && (in_item.operation == apw_pkg::OP_REQUEST)) begin
          req_row_nxt = in_item.row;
          req_col_nxt = in_item.col;
          ch_nxt      = in_item.channel;
          state_nxt   = apw_pkg::ST_SETUP;
        end
      end
      apw_pkg::ST_SETUP: begin
        h_end_nxt   = h1s[6:0];
        w_start_nxt = w0c[6:0];
        w_end_nxt   = w1s[6:0];
        h_nxt       = h0c[6:0];
        w_nxt       = w0c[6:0];
        sum_nxt     = '0;
        count_nxt   = '0;
        if (empty) begin
          out_item_nxt.average      = '0;
          out_item_nxt.window_count = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = apw_pkg::ST_IDLE;
        end else begin
          state_nxt = apw_pkg::ST_WALK;
        end
      end
      apw_pkg::ST_WALK: begin
        rd_vld_nxt = 1'b1;
        if (w_r + 7'd1 == w_end_r) begin
          w_nxt = w_start_r;
          if (h_r + 7'd1 == h_end_r) begin
            state_nxt = apw_pkg::ST_DRAIN;
          end else begin
            h_nxt = h_r + 7'd1;
          end
        end else begin
          w_nxt = w_r + 7'd1;
        end
      end
      apw_pkg::ST_DRAIN: begin
        state_nxt = apw_pkg::ST_DIV_GO;
      end
      apw_pkg::ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_nxt     = apw_pkg::ST_DIV_WAIT;
      end
      apw_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          out_item_nxt.average      = SAMPLE_W'(q_signed);
          out_item_nxt.window_count = count_r;
          out_valid_nxt = 1'b1;
          state_nxt     = apw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = apw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apw_pkg::ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    req_row_r  <= req_row_nxt;
    req_col_r  <= req_col_nxt;
    ch_r       <= ch_nxt;
    h_end_r    <= h_end_nxt;
    w_start_r  <= w_start_nxt;
    w_end_r    <= w_end_nxt;
    h_r        <= h_nxt;
    w_r        <= w_nxt;
    sum_r      <= sum_nxt;
    count_r    <= count_nxt;
  end

  assign busy      = (state_r != apw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[src/average_pool_window_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// average_pool_window_unit: 2-d average pooling over a stored HWC image
// Store items write one sample; request items return the clipped window mean.
// ---------------------------------------------------------------------------
// store item: written at the accept edge, block ready again next cycle
// request item: result on the out_valid strobe, for windows of up to 64
//   samples; an empty window skips the walk and the divider; one item at a time
// request time is set by one sample read per cycle from the single read port
//   plus the 22-step serial divider
// rst_n is synchronous: registers return to reset values, sample memory is
//   not cleared; the receiver cannot stall, each result shows for one cycle
module average_pool_window_unit #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int MAX_CHANNELS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  apw_pkg::in_item_t                 in_item,
  output logic                              busy,
  output logic                              out_valid,
  output apw_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [apw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apw_pkg::CFG_DAT_W-1:0]     cfg_data
);

  apw_pkg::cfg_t     cfg_r, cfg_nxt;
  apw_pkg::div_req_t div_req;
  apw_pkg::div_rsp_t div_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        apw_pkg::REG_IMAGE_HEIGHT:  cfg_nxt.image_height  = cfg_data;
        apw_pkg::REG_IMAGE_WIDTH:   cfg_nxt.image_width   = cfg_data;
        apw_pkg::REG_WINDOW_HEIGHT: cfg_nxt.window_height = cfg_data[3:0];
        apw_pkg::REG_WINDOW_WIDTH:  cfg_nxt.window_width  = cfg_data[3:0];
        apw_pkg::REG_STEP_ROWS:     cfg_nxt.step_rows     = cfg_data[3:0];
        apw_pkg::REG_STEP_COLS:     cfg_nxt.step_cols     = cfg_data[3:0];
        apw_pkg::REG_MARGIN_ROWS:   cfg_nxt.margin_rows   = cfg_data[2:0];
        apw_pkg::REG_MARGIN_COLS:   cfg_nxt.margin_cols   = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_height  <= 7'd64;
      cfg_r.image_width   <= 7'd64;
      cfg_r.window_height <= 4'd2;
      cfg_r.window_width  <= 4'd2;
      cfg_r.step_rows     <= 4'd2;
      cfg_r.step_cols     <= 4'd2;
      cfg_r.margin_rows   <= 3'd0;
      cfg_r.margin_cols   <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  apw_seq #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  apw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

`ifndef SYNTHESIS
  // a request goes through setup before any result, so strobes never abut
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.operation == apw_pkg::OP_REQUEST)) |=> busy)
    else $error("accepted request did not raise busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.window_count == '0)) |-> (out_item.average == '0))
    else $error("empty window gave a nonzero average");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.window_count <= 7'd64))
    else $error("window count above 64");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: average pool window unit
// A short table of stores and requests, then random store and request
// streams under a series of window settings, extremes included. Each request
// result is checked against a table value or the pooling model kept here.
// ---------------------------------------------------------------------------
module testbench;

  localparam int ROWS          = 64;
  localparam int COLS          = 64;
  localparam int CHANS         = 16;
  localparam int ITEM_TARGET   = 1550;
  localparam int PHASES        = 12;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    apw_pkg::in_item_t  item;
    bit                 typed;
    apw_pkg::out_item_t want;
  } stim_row_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          start     = 1'b0;
  apw_pkg::in_item_t             in_item   = '0;
  logic                          busy;
  logic                          out_valid;
  apw_pkg::out_item_t            out_item;
  logic                          cfg_we    = 1'b0;
  logic [apw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [apw_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

  // model of the sample store and the register set
  logic signed [apw_pkg::SAMPLE_W-1:0] pixel_mem [ROWS*COLS*CHANS];
  bit                                  pixel_written [ROWS*COLS*CHANS];
  apw_pkg::cfg_t                       pool_cfg;

  apw_pkg::out_item_t pending_means [$];
  stim_row_t          directed_rows [$];
  int                 errors      = 0;
  int                 items_sent  = 0;
  int                 cycle_count = 0;

  always #5 clk = ~clk;

  average_pool_window_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int pixel_addr(input int r, input int c, input int ch);
    return (r * COLS + c) * CHANS + ch;
  endfunction

  // clipped window rows [h0, h1) and columns [w0, w1)
  function automatic void window_bounds(input apw_pkg::in_item_t it, output int h0,
                                        output int h1, output int w0, output int w1);
    int hl, wl, wh, ww;
    hl = (int'(pool_cfg.image_height) > ROWS) ? ROWS : int'(pool_cfg.image_height);
    wl = (int'(pool_cfg.image_width) > COLS) ? COLS : int'(pool_cfg.image_width);
    wh = (int'(pool_cfg.window_height) > apw_pkg::WIN_LIMIT) ? apw_pkg::WIN_LIMIT
                                                              : int'(pool_cfg.window_height);
    ww = (int'(pool_cfg.window_width) > apw_pkg::WIN_LIMIT) ? apw_pkg::WIN_LIMIT
                                                             : int'(pool_cfg.window_width);
    h0 = int'(it.row) * int'(pool_cfg.step_rows) - int'(pool_cfg.margin_rows);
    w0 = int'(it.col) * int'(pool_cfg.step_cols) - int'(pool_cfg.margin_cols);
    h1 = (h0 + wh > hl) ? hl : h0 + wh;
    w1 = (w0 + ww > wl) ? wl : w0 + ww;
    if (h0 < 0) h0 = 0;
    if (w0 < 0) w0 = 0;
  endfunction

  function automatic apw_pkg::out_item_t window_mean(input apw_pkg::in_item_t it);
    apw_pkg::out_item_t r;
    int h0, h1, w0, w1;
    int sum, count, avg;
    sum   = 0;
    count = 0;
    avg   = 0;
    window_bounds(it, h0, h1, w0, w1);
    for (int h = h0; h < h1; h++) begin
      for (int w = w0; w < w1; w++) begin
        sum += int'(pixel_mem[pixel_addr(h, w, int'(it.channel))]);
        count++;
      end
    end
    // integer division truncates toward zero
    if (count > 0) avg = sum / count;
    r.average      = avg[apw_pkg::SAMPLE_W-1:0];
    r.window_count = count[apw_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [apw_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // highest output position whose window start does not pass the image edge
  function automatic int reach_limit(input int extent, input int step, input int margin);
    int ext, v;
    ext = (extent > ROWS) ? ROWS : extent;
    if (step == 0) return 63;
    v = (ext + margin) / step;
    return (v > 63) ? 63 : v;
  endfunction

  task automatic add_row(input logic op, input int r, input int c, input int ch,
                         input logic signed [apw_pkg::SAMPLE_W-1:0] sample,
                         input bit typed,
                         input logic signed [apw_pkg::SAMPLE_W-1:0] avg, input int cnt);
    stim_row_t s;
    s.item.operation     = op;
    s.item.row           = r[apw_pkg::ROW_W-1:0];
    s.item.col           = c[apw_pkg::COL_W-1:0];
    s.item.channel       = ch[apw_pkg::CHAN_W-1:0];
    s.item.sample        = sample;
    s.typed              = typed;
    s.want.average       = avg;
    s.want.window_count  = cnt[apw_pkg::COUNT_W-1:0];
    directed_rows.push_back(s);
  endtask

  task automatic send_item(input apw_pkg::in_item_t it, input bit typed,
                           input apw_pkg::out_item_t want);
    int idle_pct, gap, a;
    if (items_sent < ITEM_TARGET / 3) idle_pct = 19;
    else if (items_sent < 2 * ITEM_TARGET / 3) idle_pct = 45;
    else idle_pct = 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (it.operation == apw_pkg::OP_STORE) begin
      a = pixel_addr(int'(it.row), int'(it.col), int'(it.channel));
      pixel_mem[a]     = it.sample;
      pixel_written[a] = 1'b1;
    end else begin
      pending_means.push_back(typed ? want : window_mean(it));
    end
  endtask

  // stores fill every window entry not yet written and rewrite some at random, then the request goes out
  task automatic request_window(input apw_pkg::in_item_t req);
    apw_pkg::in_item_t st;
    int h0, h1, w0, w1;
    window_bounds(req, h0, h1, w0, w1);
    for (int h = h0; h < h1; h++) begin
      for (int w = w0; w < w1; w++) begin
        if (!pixel_written[pixel_addr(h, w, int'(req.channel))]
            || $urandom_range(0, 9) == 0) begin
          st.operation = apw_pkg::OP_STORE;
          st.row       = h[apw_pkg::ROW_W-1:0];
          st.col       = w[apw_pkg::COL_W-1:0];
          st.channel   = req.channel;
          st.sample    = pick_sample();
          send_item(st, 1'b0, '0);
        end
      end
    end
    send_item(req, 1'b0, '0);
  endtask

  task automatic random_item();
    apw_pkg::in_item_t it;
    int sel, rtop, ctop;
    sel        = $urandom_range(0, 99);
    it.row     = 6'($urandom_range(0, 63));
    it.col     = 6'($urandom_range(0, 63));
    it.channel = 4'($urandom_range(0, 15));
    it.sample  = pick_sample();
    if (sel < 20) begin
      it.operation = apw_pkg::OP_STORE;
      send_item(it, 1'b0, '0);
    end else begin
      it.operation = apw_pkg::OP_REQUEST;
      if (sel < 85) begin
        // mostly near the origin so earlier stores get reused
        rtop = reach_limit(int'(pool_cfg.image_height), int'(pool_cfg.step_rows),
                           int'(pool_cfg.margin_rows));
        ctop = reach_limit(int'(pool_cfg.image_width), int'(pool_cfg.step_cols),
                           int'(pool_cfg.margin_cols));
        if ($urandom_range(0, 3) != 0) begin
          if (rtop > 3) rtop = 3;
          if (ctop > 3) ctop = 3;
        end
        it.row = 6'($urandom_range(0, rtop));
        it.col = 6'($urandom_range(0, ctop));
        if ($urandom_range(0, 3) != 0) it.channel = 4'($urandom_range(0, 1));
      end
      request_window(it);
    end
  endtask

  task automatic write_cfg(input logic [apw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apw_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      apw_pkg::REG_IMAGE_HEIGHT:  pool_cfg.image_height  = data[6:0];
      apw_pkg::REG_IMAGE_WIDTH:   pool_cfg.image_width   = data[6:0];
      apw_pkg::REG_WINDOW_HEIGHT: pool_cfg.window_height = data[3:0];
      apw_pkg::REG_WINDOW_WIDTH:  pool_cfg.window_width  = data[3:0];
      apw_pkg::REG_STEP_ROWS:     pool_cfg.step_rows     = data[3:0];
      apw_pkg::REG_STEP_COLS:     pool_cfg.step_cols     = data[3:0];
      apw_pkg::REG_MARGIN_ROWS:   pool_cfg.margin_rows   = data[2:0];
      apw_pkg::REG_MARGIN_COLS:   pool_cfg.margin_cols   = data[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [6:0] ih, input logic [6:0] iw,
                                input logic [6:0] wh, input logic [6:0] ww,
                                input logic [6:0] sr, input logic [6:0] sc,
                                input logic [6:0] mr, input logic [6:0] mc);
    write_cfg(apw_pkg::REG_IMAGE_HEIGHT, ih);
    write_cfg(apw_pkg::REG_IMAGE_WIDTH, iw);
    write_cfg(apw_pkg::REG_WINDOW_HEIGHT, wh);
    write_cfg(apw_pkg::REG_WINDOW_WIDTH, ww);
    write_cfg(apw_pkg::REG_STEP_ROWS, sr);
    write_cfg(apw_pkg::REG_STEP_COLS, sc);
    write_cfg(apw_pkg::REG_MARGIN_ROWS, mr);
    write_cfg(apw_pkg::REG_MARGIN_COLS, mc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender holds off until every result is back and the unit has gone quiet
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    apw_pkg::out_item_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (rst_n && out_valid !== 1'b0) begin
      if (pending_means.size() == 0) begin
        errors++;
        $display("%0t unexpected result: average %0d window_count %0d", $time,
                 $signed(out_item.average), out_item.window_count);
      end else begin
        want = pending_means.pop_front();
        if (out_item.average !== want.average) begin
          errors++;
          $display("%0t average mismatch: expected %0d actual %0d", $time,
                   $signed(want.average), $signed(out_item.average));
        end
        if (out_item.window_count !== want.window_count) begin
          errors++;
          $display("%0t window_count mismatch: expected %0d actual %0d", $time,
                   want.window_count, out_item.window_count);
        end
      end
    end
  end

  initial begin
    pool_cfg = '{image_height: 7'd64, image_width: 7'd64, window_height: 4'd2,
                 window_width: 4'd2, step_rows: 4'd2, step_cols: 4'd2,
                 margin_rows: 3'd0, margin_cols: 3'd0};

    // full-scale positive and negative windows
    add_row(apw_pkg::OP_STORE, 0, 0, 0, 16'sh7FFF, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 0, 1, 0, 16'sh7FFF, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 1, 0, 0, 16'sh7FFF, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 1, 1, 0, 16'sh7FFF, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_REQUEST, 0, 0, 0, 16'sd0, 1'b1, 16'sh7FFF, 4);
    add_row(apw_pkg::OP_STORE, 0, 0, 1, 16'sh8000, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 0, 1, 1, 16'sh8000, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 1, 0, 1, 16'sh8000, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 1, 1, 1, 16'sh8000, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_REQUEST, 0, 0, 1, 16'sh7FFF, 1'b1, 16'sh8000, 4);
    // -5 / 4 truncates to -1, not -2
    add_row(apw_pkg::OP_STORE, 0, 0, 2, -16'sd1, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 0, 1, 2, -16'sd1, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 1, 0, 2, -16'sd1, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 1, 1, 2, -16'sd2, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_REQUEST, 0, 0, 2, 16'sd0, 1'b1, -16'sd1, 4);
    // far corner of the image, top channel
    add_row(apw_pkg::OP_STORE, 62, 62, 15, 16'sh0100, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 62, 63, 15, 16'sh0200, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 63, 62, 15, 16'sh0300, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 63, 63, 15, 16'sh0400, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_REQUEST, 31, 31, 15, 16'sd0, 1'b0, 16'sd0, 0);
    // window starts past the last row: empty
    add_row(apw_pkg::OP_REQUEST, 63, 63, 7, 16'sh5555, 1'b1, 16'sd0, 0);
    add_row(apw_pkg::OP_STORE, 63, 63, 15, -16'sh5556, 1'b0, 16'sd0, 0);
    add_row(apw_pkg::OP_REQUEST, 31, 31, 15, 16'shAAAA, 1'b0, 16'sd0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain_results();
        case (phase)
          1: apply_settings(7'd64, 7'd64, 7'd8, 7'd8, 7'd1, 7'd1, 7'd7, 7'd7);
          2: apply_settings(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd0, 7'd0);
          // zero height: every window empty
          3: apply_settings(7'd0, 7'd127, 7'd3, 7'd3, 7'd1, 7'd1, 7'd0, 7'd0);
          // oversize image and window saturate
          4: apply_settings(7'd127, 7'd127, 7'd15, 7'd15, 7'd8, 7'd8, 7'd3, 7'd5);
          // zero window height, zero strides
          5: apply_settings(7'd10, 7'd12, 7'd0, 7'd4, 7'd0, 7'd0, 7'd2, 7'd1);
          // all-ones data, upper bits dropped by narrow registers
          6: apply_settings(7'd20, 7'd9, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
          7: apply_settings(7'd64, 7'd1, 7'd8, 7'd1, 7'd1, 7'd8, 7'd0, 7'd0);
          default:
            apply_settings(7'($urandom_range(1, 32)), 7'($urandom_range(1, 32)),
                           7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                           7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                           7'($urandom_range(0, 7)), 7'($urandom_range(0, 7)));
        endcase
      end
      while (items_sent < ITEM_TARGET * (phase + 1) / PHASES) random_item();
    end

    drain_results();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
